// File: src/assert_macros.svh
// assertion helpers shared by the rtl files
// every check is clocked on aclk and disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gkg_pkg.sv
// ----------------------------------------------------------------------------
// gkg_pkg
// types, constants and the fixed sigma 1.0 table of the kernel generator
// ----------------------------------------------------------------------------
package gkg_pkg;

    localparam int DIV_W = 48;

    localparam logic [31:0] E1_Q32    = 32'd1580030168;
    localparam logic [15:0] SIGMA_ONE = 16'd256;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [3:0]  TAYLOR_LAST = 4'd13;

    typedef struct packed {
        logic [7:0]  tap_count;
        logic [15:0] sigma;
    } in_item_t;

    typedef struct packed {
        logic [15:0] coefficient;
        logic [5:0]  tap_index;
        logic        last;
        logic        ok;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQW,
        ST_DSQ,
        ST_XDIV,
        ST_XWAIT,
        ST_TMUL,
        ST_TDIV,
        ST_TWAIT,
        ST_TFIN,
        ST_KMUL,
        ST_KW,
        ST_STORE,
        ST_RD,
        ST_NDIV,
        ST_NWAIT,
        ST_TAB,
        ST_OUT
    } state_t;

    // fixed coefficients for sigma 1.0, selected by tap count and position
    function automatic logic [15:0] tab_coef(input logic [2:0] n, input logic [2:0] k);
        logic [15:0] c;
        c = 16'd0;
        case (n)
            3'd3: begin
                case (k)
                    3'd1:    c = 16'd14628;
                    default: c = 16'd8992;
                endcase
            end
            3'd5: begin
                case (k)
                    3'd0, 3'd4: c = 16'd1786;
                    3'd1, 3'd3: c = 16'd7995;
                    default:    c = 16'd13206;
                endcase
            end
            default: begin
                case (k)
                    3'd0, 3'd6: c = 16'd131;
                    3'd1, 3'd5: c = 16'd1773;
                    3'd2, 3'd4: c = 16'd7930;
                    default:    c = 16'd13107;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// File: src/gaussian_kernel_generator.sv
// ----------------------------------------------------------------------------
// gaussian_kernel_generator
// normalized 1-D gaussian coefficients in Q1.15 from a tap count and sigma
// ----------------------------------------------------------------------------
//  channel  ports                     payload        direction
//  s_       s_valid s_ready s_data    in_item_t      request in
//  m_       m_valid m_ready m_data    out_item_t     one coefficient out
//
//  computed kernel: per tap, 15 passes through the 48-step shared divider
//  (exponent, 13 series terms, normalize) plus one multiply per exp(-1)
//  factor; a cut-off tap skips the series and the factors, and each
//  request first squares sigma
//  table kernel: one table lookup per result; rejected request: one result
//  s_ready is high only in idle; one request is handled at a time
//  reset is synchronous on aresetn; no clearing pass is needed
//  results stall freely on m_ready, the output register holds them
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_kernel_generator #(
    parameter int MAX_TAPS = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gkg_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gkg_pkg::out_item_t  m_data
);

    import gkg_pkg::*;

    // tap position width and the width that holds the sum of all weights
    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int SUM_W = 32 + $clog2(MAX_TAPS + 1);

    state_t              state_reg, state_next;
    logic [7:0]          n_reg, n_next;
    logic [15:0]         s_reg, s_next;
    logic [31:0]         ssq_reg, ssq_next;
    logic [TAP_W-1:0]    k_reg, k_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [31:0]         f_reg, f_next;
    logic [4:0]          kcnt_reg, kcnt_next;
    logic [32:0]         term_reg, term_next;
    logic signed [34:0]  acc_reg, acc_next;
    logic [3:0]          j_reg, j_next;
    logic [32:0]         w_reg, w_next;
    logic                tab_reg, tab_next;
    out_item_t           out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    // weight store for the normalize pass
    logic [32:0]         w_mem [MAX_TAPS];
    logic [32:0]         rd_reg;

    logic [32:0]         mul_a;
    logic [31:0]         mul_b;
    logic [64:0]         prod;

    logic                div_start;
    logic [DIV_W-1:0]    div_dvd;
    logic [SUM_W-1:0]    div_dvs;
    logic [DIV_W-1:0]    div_quo;
    div_stat_t           div_stat;

    logic                in_fire;
    logic                in_bad;
    logic                in_tab;
    logic                at_last_tap;
    logic [TAP_W-1:0]    half;
    logic [TAP_W-1:0]    tap_offs;
    logic signed [34:0]  acc_upd;

    gkg_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    gkg_div #(
        .DVS_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    // rejected: sigma zero, even count, count too large, single tap at 1.0
    assign in_bad = (s_data.sigma == 16'd0) || !s_data.tap_count[0]
                 || (s_data.tap_count > 8'(MAX_TAPS))
                 || ((s_data.tap_count == 8'd1) && (s_data.sigma == SIGMA_ONE));
    assign in_tab = (s_data.sigma == SIGMA_ONE)
                 && ((s_data.tap_count == 8'd3) || (s_data.tap_count == 8'd5)
                  || (s_data.tap_count == 8'd7));

    assign at_last_tap = ((8'(k_reg) + 8'd1) == n_reg);
    assign half        = TAP_W'(n_reg >> 1);
    assign tap_offs    = (k_reg >= half) ? (k_reg - half) : (half - k_reg);

    // series terms alternate in sign, odd steps subtract
    assign acc_upd = j_reg[0] ? (acc_reg - $signed({2'b00, div_quo[32:0]}))
                              : (acc_reg + $signed({2'b00, div_quo[32:0]}));

    // multiplier operands follow the issuing state
    always_comb begin
        case (state_reg)
            ST_SQ: begin
                mul_a = 33'(s_reg);
                mul_b = 32'(s_reg);
            end
            ST_DSQ: begin
                mul_a = 33'(tap_offs);
                mul_b = 32'(tap_offs);
            end
            ST_TMUL: begin
                mul_a = term_reg;
                mul_b = f_reg;
            end
            default: begin
                mul_a = w_reg;
                mul_b = E1_Q32;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_bad) begin
                        state_next = ST_OUT;
                    end else if (in_tab) begin
                        state_next = ST_TAB;
                    end else begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:    state_next = ST_SQW;
            ST_SQW:   state_next = ST_DSQ;
            ST_DSQ:   state_next = ST_XDIV;
            ST_XDIV:  state_next = ST_XWAIT;
            ST_XWAIT: begin
                if (div_stat.done) begin
                    // exponent of 32 or more underflows to a zero weight
                    if (div_quo[DIV_W-1:21] != '0) begin
                        state_next = ST_STORE;
                    end else begin
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_TMUL:  state_next = ST_TDIV;
            ST_TDIV:  state_next = ST_TWAIT;
            ST_TWAIT: begin
                if (div_stat.done) begin
                    state_next = (j_reg == TAYLOR_LAST) ? ST_TFIN : ST_TMUL;
                end
            end
            ST_TFIN:  state_next = (kcnt_reg != 5'd0) ? ST_KMUL : ST_STORE;
            ST_KMUL:  state_next = ST_KW;
            ST_KW:    state_next = (kcnt_reg == 5'd1) ? ST_STORE : ST_KMUL;
            ST_STORE: state_next = at_last_tap ? ST_RD : ST_DSQ;
            ST_RD:    state_next = ST_NDIV;
            ST_NDIV:  state_next = ST_NWAIT;
            ST_NWAIT: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_TAB:   state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    if (out_reg.last) begin
                        state_next = ST_IDLE;
                    end else if (tab_reg) begin
                        state_next = ST_TAB;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_next       = n_reg;
        s_next       = s_reg;
        ssq_next     = ssq_reg;
        k_next       = k_reg;
        sum_next     = sum_reg;
        f_next       = f_reg;
        kcnt_next    = kcnt_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        j_next       = j_reg;
        w_next       = w_reg;
        tab_next     = tab_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        div_start    = 1'b0;
        div_dvd      = 48'(prod[2*TAP_W-1:0]) << 31;
        div_dvs      = SUM_W'(ssq_reg);
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    n_next   = s_data.tap_count;
                    s_next   = s_data.sigma;
                    k_next   = '0;
                    tab_next = in_tab;
                    if (in_bad) begin
                        out_next     = '{coefficient: 16'd0, tap_index: 6'd0,
                                         last: 1'b1, ok: 1'b0};
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_SQW: begin
                ssq_next = prod[31:0];
                sum_next = '0;
                k_next   = '0;
            end
            ST_XDIV: begin
                // x = i^2 * 2^31 / s^2 in Q16
                div_start = 1'b1;
            end
            ST_XWAIT: begin
                if (div_stat.done) begin
                    w_next    = 33'd0;
                    kcnt_next = div_quo[20:16];
                    f_next    = {div_quo[15:0], 16'd0};
                    term_next = ONE_Q32;
                    acc_next  = 35'(ONE_Q32);
                    j_next    = 4'd1;
                end
            end
            ST_TDIV: begin
                div_start = 1'b1;
                div_dvd   = 48'(prod[64:32]);
                div_dvs   = SUM_W'(j_reg);
            end
            ST_TWAIT: begin
                if (div_stat.done) begin
                    term_next = div_quo[32:0];
                    acc_next  = acc_upd;
                    j_next    = j_reg + 4'd1;
                end
            end
            ST_TFIN: begin
                w_next = acc_reg[34] ? 33'd0 : acc_reg[32:0];
            end
            ST_KW: begin
                // one factor of exp(-1) per integer step of the exponent
                w_next    = prod[64:32];
                kcnt_next = kcnt_reg - 5'd1;
            end
            ST_STORE: begin
                sum_next = sum_reg + SUM_W'(w_reg);
                k_next   = at_last_tap ? '0 : (k_reg + 1'b1);
            end
            ST_NDIV: begin
                // rounded w * 2^15 / sum
                div_start = 1'b1;
                div_dvd   = (48'(rd_reg) << 15) + 48'(sum_reg >> 1);
                div_dvs   = sum_reg;
            end
            ST_NWAIT: begin
                if (div_stat.done) begin
                    out_next     = '{coefficient: div_quo[15:0], tap_index: 6'(k_reg),
                                     last: at_last_tap, ok: 1'b1};
                    m_valid_next = 1'b1;
                end
            end
            ST_TAB: begin
                out_next     = '{coefficient: tab_coef(n_reg[2:0], 3'(k_reg)),
                                 tap_index: 6'(k_reg), last: at_last_tap, ok: 1'b1};
                m_valid_next = 1'b1;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (!out_reg.last) begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg    <= n_next;
        s_reg    <= s_next;
        ssq_reg  <= ssq_next;
        k_reg    <= k_next;
        sum_reg  <= sum_next;
        f_reg    <= f_next;
        kcnt_reg <= kcnt_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        j_reg    <= j_next;
        w_reg    <= w_next;
        tab_reg  <= tab_next;
        out_reg  <= out_next;
    end

    // weight memory: written per tap, read back for normalize
    always_ff @(posedge aclk) begin
        if (state_reg == ST_STORE) begin
            w_mem[k_reg] <= w_reg;
        end
        rd_reg <= w_mem[k_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `ASSERT_IMPL(a_valid_in_out, m_valid_reg, state_reg == ST_OUT, "result valid outside output")
    `ASSERT_IMPL(a_div_free, div_start, !div_stat.busy, "divider issued while busy")
    `ASSERT_NEXT(a_last_idle, m_valid && m_ready && m_data.last, s_ready,
                 "not idle after last result")

endmodule

// File: src/gkg_mul.sv
// ----------------------------------------------------------------------------
// gkg_mul
// shared registered multiplier, 33 x 32 bits
// ----------------------------------------------------------------------------
module gkg_mul (
    input  logic        aclk,
    input  logic [32:0] a,
    input  logic [31:0] b,
    output logic [64:0] p
);

    logic [64:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= 65'(a) * 65'(b);
    end

    assign p = p_reg;

endmodule

// File: src/gkg_div.sv
// ----------------------------------------------------------------------------
// gkg_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gkg_div #(
    parameter int DVS_W = 38
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [gkg_pkg::DIV_W-1:0]  dividend,
    input  logic [DVS_W-1:0]           divisor,
    output logic [gkg_pkg::DIV_W-1:0]  quotient,
    output gkg_pkg::div_stat_t         stat
);

    import gkg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_ALWAYS(a_div_no_restart, !(start && busy_reg), "divider started while busy")
    `ASSERT_IMPL(a_div_done_idle, done_reg, !busy_reg, "divider done while still busy")
    `ASSERT_NEXT(a_div_start_busy, start, busy_reg && !done_reg, "divider did not start")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks gaussian_kernel_generator against a bit-exact coefficient predictor
// under random idling on both channels, table, computed and rejected requests
// ----------------------------------------------------------------------------
module tb_top;
    import gkg_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    gaussian_kernel_generator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    localparam int N_TAPS_MAX = 63;
    localparam int DRAIN_WAIT = 64;

    in_item_t  pending_reqs[$];
    bit        drain_first[$];     // request waits until all coefficients are out
    out_item_t expected_coefs[$];
    int        n_errors;
    int        send_gap;
    int        recv_stall;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // random wait: mostly none, so there are long stretches without idling
    function automatic int draw_wait();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    // exp(-f) for a Q32 fraction, 14-term alternating series
    function automatic logic [63:0] exp_frac_q32(logic [63:0] f);
        longint      acc;
        logic [63:0] term;
        acc  = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        for (int j = 1; j <= 13; j++) begin
            term = ((term * f) >> 32) / j;
            if (j % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        return 64'(acc);
    endfunction

    // unnormalized weight in Q32 for squared offset i2 and Q8.8 sigma s
    function automatic logic [63:0] gauss_weight(logic [63:0] i2, logic [63:0] s);
        logic [63:0] x;
        logic [63:0] w;
        x = (i2 << 31) / (s * s);
        if (x >= (64'd32 << 16)) return 64'd0;
        w = exp_frac_q32((x & 64'hFFFF) << 16);
        for (int k = 0; k < int'(x >> 16); k++)
            w = (w * 64'(E1_Q32)) >> 32;
        return w;
    endfunction

    // appends the coefficients one request should produce
    task automatic predict_kernel(in_item_t req);
        logic [63:0] w[N_TAPS_MAX];
        logic [63:0] sum;
        out_item_t   r;
        int          n;
        int          half;
        int          d;
        n   = req.tap_count;
        sum = 0;
        if (req.sigma == 0 || n % 2 == 0 || n > N_TAPS_MAX ||
            (n == 1 && req.sigma == SIGMA_ONE)) begin
            r = '{coefficient: 16'd0, tap_index: 6'd0, last: 1'b1, ok: 1'b0};
            expected_coefs.push_back(r);
        end else if (req.sigma == SIGMA_ONE && n <= 7) begin
            // sigma 1.0 with 3, 5 or 7 taps uses the fixed table
            for (int k = 0; k < n; k++) begin
                r.coefficient = tab_coef(3'(n), 3'(k));
                r.tap_index   = 6'(k);
                r.last        = (k == n - 1);
                r.ok          = 1'b1;
                expected_coefs.push_back(r);
            end
        end else begin
            half = n / 2;
            for (int k = 0; k < n; k++) begin
                d    = (k >= half) ? k - half : half - k;
                w[k] = gauss_weight(64'(d * d), 64'(req.sigma));
                sum  = sum + w[k];
            end
            for (int k = 0; k < n; k++) begin
                r.coefficient = 16'(((w[k] << 15) + (sum >> 1)) / sum);
                r.tap_index   = 6'(k);
                r.last        = (k == n - 1);
                r.ok          = 1'b1;
                expected_coefs.push_back(r);
            end
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic add_req(int n, int s, bit hold);
        in_item_t r;
        r.tap_count = 8'(n);
        r.sigma     = 16'(s);
        pending_reqs.push_back(r);
        drain_first.push_back(hold);
    endtask

    // request driver: one valid assignment per edge, prediction on accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            send_gap <= 0;
        end else begin : drive
            logic v;
            v = s_valid;
            if (s_valid && s_ready) begin
                predict_kernel(s_data);
                v = 1'b0;
                send_gap <= draw_wait();
            end else if (!v && send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (!v && pending_reqs.size() > 0) begin
                if (!drain_first[0] || expected_coefs.size() == 0) begin
                    v = 1'b1;
                    s_data <= pending_reqs.pop_front();
                    void'(drain_first.pop_front());
                end
            end
            s_valid <= v;
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin : check
                out_item_t e;
                if (expected_coefs.size() == 0) begin
                    report("unexpected result, tap_index", m_data.tap_index, -1);
                end else begin
                    e = expected_coefs.pop_front();
                    if (m_data.coefficient !== e.coefficient)
                        report("coefficient", m_data.coefficient, e.coefficient);
                    if (m_data.tap_index !== e.tap_index)
                        report("tap_index", m_data.tap_index, e.tap_index);
                    if (m_data.last !== e.last) report("last", m_data.last, e.last);
                    if (m_data.ok !== e.ok) report("ok", m_data.ok, e.ok);
                end
                recv_stall <= draw_wait();
                m_ready    <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        int s;
        n_errors = 0;
        aresetn  = 1'b0;

        // directed: table kernels, rejects, extremes, cutoff and flat kernels
        add_req(3, 256, 0);
        add_req(5, 256, 0);
        add_req(7, 256, 0);
        add_req(1, 256, 0);       // single tap at sigma 1.0 is rejected
        add_req(0, 256, 0);
        add_req(2, 0, 0);
        add_req(4, 300, 0);
        add_req(65, 256, 0);
        add_req(255, 16'hFFFF, 0);
        add_req(3, 0, 0);
        add_req(1, 500, 0);       // single tap elsewhere gives full weight
        add_req(1, 16'hFFFF, 1);
        add_req(9, 256, 0);       // sigma 1.0 beyond the table is computed
        add_req(9, 1, 0);         // tiny sigma, outer taps cut off
        add_req(3, 16'hFFFF, 0);
        add_req(7, 257, 0);
        add_req(15, 512, 0);
        add_req(63, 16'hFFFF, 0);
        add_req(63, 1, 1);
        add_req(11, 128, 0);
        add_req(5, 16'h5555, 0);
        add_req(5, 16'hAAAA, 0);

        for (int i = 0; i < 300; i++) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(0, 255);              // mostly rejected
                1: n = 2 * $urandom_range(0, 3) + 3;        // table sizes
                2: n = ($urandom_range(0, 15) == 0) ? 63 : 2 * $urandom_range(0, 15) + 1;
                default: n = 2 * $urandom_range(0, 4) + 1;
            endcase
            case ($urandom_range(0, 5))
                0: s = 256;
                1: s = $urandom_range(0, 255);
                2: s = $urandom_range(0, 65535);
                3: s = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                default: s = $urandom_range(100, 2000);
            endcase
            add_req(n, s, $urandom_range(0, 19) == 0);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_coefs.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (n_errors == 0 && expected_coefs.size() == 0) begin
            $display("[gaussian_kernel_generator] OK");
        end else begin
            $display("[gaussian_kernel_generator] ERROR");
        end
        $finish;
    end

    // worst case: every request a full computed kernel under maximum stalls
    initial begin
        #(64'd4_000_000_000);
        $display("[gaussian_kernel_generator] ERROR");
        $finish;
    end

endmodule
